/* design/assert_macros.svh */
// Assertion macros shared by the sorted list design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define SLSI_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// When the antecedent holds, the consequent must hold in the cycle after.
`define SLSI_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/slsi_pkg.sv */
// Types and constants shared by the sorted list insert and delete design.
package slsi_pkg;

	localparam int CAPACITY_DEF = 16;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_READ   = 2'd2,
		OP_NOP    = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_RANK      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_CMP,
		PH_UPD
	} phase_t;

	typedef struct packed {
		opcode_t            opcode;
		logic signed [31:0] value;
		logic [3:0]         rank;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] read_value;
		logic [4:0]         count;
		logic               empty_res;
	} rsp_t;

	// Broadcast from the controller to every cell of the chain.
	typedef struct packed {
		logic               cmp_en;
		logic               ins_en;
		logic               del_en;
		logic signed [31:0] value;
	} cell_ctl_t;

endpackage

/* design/slsi_cell.sv */
// One cell of the sorted chain: holds a single entry and its compare flags.
module slsi_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  slsi_pkg::cell_ctl_t ctl,
	input  logic                occ,
	input  logic                at_end,
	input  logic                left_gt,
	input  logic signed [31:0]  left_val,
	input  logic signed [31:0]  right_val,
	output logic signed [31:0]  val,
	output logic                gt,
	output logic                eq
);

	logic signed [31:0] val_q;
	logic               gt_q;
	logic               eq_q;

	// Flags are taken in the compare cycle and used in the update cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (ctl.cmp_en) begin
			gt_q <= occ && (val_q > ctl.value);
			eq_q <= occ && (val_q == ctl.value);
		end
	end

	// An insert moves every larger entry up by one; the first larger cell, or the
	// first free cell when none is larger, takes the new value. A delete pulls the
	// matching entry and everything above it down by one.
	always_ff @(posedge clk) begin
		if (ctl.ins_en) begin
			if (left_gt) begin
				val_q <= left_val;
			end else if (gt_q || at_end) begin
				val_q <= ctl.value;
			end
		end else if (ctl.del_en && (eq_q || gt_q)) begin
			val_q <= right_val;
		end
	end

	assign val = val_q;
	assign gt  = gt_q;
	assign eq  = eq_q;

endmodule

/* design/sorted_list_insert_delete_top.sv */
// Sorted list top level: a chain of cells that keeps signed values in order.
//
// The block holds up to CAPACITY signed 32-bit values in ascending order in a
// row of cells. Each request (insert, delete or read by rank) has a compare
// step, in which every cell compares its entry with the broadcast value at
// once, and then an update step, in which the cells shift by one place towards
// or away from the insertion or match point while the result is formed. A new
// request is taken in the same cycle as the update of the one before, but not
// during its compare step. Each request gives exactly one result, held in an
// output register, so a request may be taken while the previous result still
// waits; the update step waits only while that register is occupied and its
// result is stalled. Every result carries a status, the entry count after the
// operation (its low five bits) and an empty flag. Inserting into a full list,
// deleting a value that is not present and reading at a rank not below the
// count give an error status and leave the list unchanged.
`include "assert_macros.svh"

module sorted_list_insert_delete_top #(
	parameter int CAPACITY = slsi_pkg::CAPACITY_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  slsi_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output slsi_pkg::rsp_t rsp
);

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CXW  = CW + 5;
	localparam int RW   = (CW > 4) ? CW : 4;
	localparam int RD_N = (CAPACITY < 16) ? CAPACITY : 16;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	slsi_pkg::phase_t   phase_q;
	slsi_pkg::phase_t   phase_d;
	slsi_pkg::req_t     req_s1;
	slsi_pkg::rsp_t     rsp_q;
	slsi_pkg::rsp_t     rsp_d;
	slsi_pkg::cell_ctl_t ctl;
	logic               rsp_valid_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_d;
	logic [CXW-1:0]     count_ext;
	logic               accept;
	logic               upd_go;
	logic               full;
	logic               found;
	logic               rank_ok;
	logic [RW-1:0]      rank_x;
	logic [RW-1:0]      count_x;
	logic signed [31:0] rd_val;
	logic signed [31:0] cell_val [CAPACITY];
	logic [CAPACITY-1:0] cell_gt;
	logic [CAPACITY-1:0] cell_eq;

	// The update step completes only when the output register is free or is
	// being emptied in this cycle.
	assign upd_go    = (phase_q == slsi_pkg::PH_UPD) && (!rsp_valid_q || !rsp_stall);
	assign req_stall = !((phase_q == slsi_pkg::PH_IDLE) || upd_go);
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= slsi_pkg::PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			phase_d = slsi_pkg::PH_CMP;
		end else begin
			case (phase_q)
				slsi_pkg::PH_CMP: phase_d = slsi_pkg::PH_UPD;
				slsi_pkg::PH_UPD: phase_d = upd_go ? slsi_pkg::PH_IDLE : slsi_pkg::PH_UPD;
				default:          phase_d = slsi_pkg::PH_IDLE;
			endcase
		end
	end

	// The request is held through its compare and update steps.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	assign full  = (count_q == CAP_C);
	assign found = |cell_eq;

	// Control broadcast to the whole chain.
	always_comb begin
		ctl.cmp_en = (phase_q == slsi_pkg::PH_CMP);
		ctl.ins_en = upd_go && (req_s1.opcode == slsi_pkg::OP_INSERT) && !full;
		ctl.del_en = upd_go && (req_s1.opcode == slsi_pkg::OP_DELETE) && found;
		ctl.value  = req_s1.value;
	end

	// The chain of cells. Occupancy follows from the count, so a cell needs no
	// valid bit of its own.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [CW-1:0] IDX = CW'(i);
		logic               left_gt;
		logic signed [31:0] left_val;
		logic signed [31:0] right_val;

		if (i == 0) begin : g_first
			assign left_gt  = 1'b0;
			assign left_val = '0;
		end else begin : g_inner
			assign left_gt  = cell_gt[i-1];
			assign left_val = cell_val[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_val = '0;
		end else begin : g_body
			assign right_val = cell_val[i+1];
		end

		slsi_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.occ       (IDX < count_q),
			.at_end    (IDX == count_q),
			.left_gt   (left_gt),
			.left_val  (left_val),
			.right_val (right_val),
			.val       (cell_val[i]),
			.gt        (cell_gt[i]),
			.eq        (cell_eq[i])
		);
	end

	// Reading by rank only reaches the lowest sixteen cells, or all when fewer.
	always_comb begin
		rd_val = '0;
		for (int k = 0; k < RD_N; k++) begin
			if (req_s1.rank == 4'(k)) begin
				rd_val = rd_val | cell_val[k];
			end
		end
	end

	assign rank_x  = RW'(req_s1.rank);
	assign count_x = RW'(count_q);
	assign rank_ok = (rank_x < count_x);

	// Result and new count of the request in its update cycle.
	always_comb begin
		count_d        = count_q;
		rsp_d.status   = slsi_pkg::ST_OK;
		rsp_d.read_value = '0;
		case (req_s1.opcode)
			slsi_pkg::OP_INSERT: begin
				if (full) begin
					rsp_d.status = slsi_pkg::ST_FULL;
				end else begin
					count_d = count_q + 1'b1;
				end
			end
			slsi_pkg::OP_DELETE: begin
				if (found) begin
					count_d = count_q - 1'b1;
				end else begin
					rsp_d.status = slsi_pkg::ST_NOT_FOUND;
				end
			end
			slsi_pkg::OP_READ: begin
				if (rank_ok) begin
					rsp_d.read_value = rd_val;
				end else begin
					rsp_d.status = slsi_pkg::ST_RANK;
				end
			end
			default: begin
				rsp_d.status = slsi_pkg::ST_OK;
			end
		endcase
		count_ext       = CXW'(count_d);
		rsp_d.count     = count_ext[4:0];
		rsp_d.empty_res = (count_d == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (upd_go) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The list never holds more entries than it has cells.
	`SLSI_ASSERT(a_count_bound, count_q <= CAP_C, "entry count exceeds capacity")
	// An insert into a full list leaves the count alone.
	`SLSI_ASSERT_NEXT(a_full_hold, upd_go && (req_s1.opcode == slsi_pkg::OP_INSERT) && full, $stable(count_q), "count changed on insert into full list")
	// A successful delete removes exactly one entry.
	`SLSI_ASSERT_NEXT(a_del_count, ctl.del_en, count_q == CW'($past(count_q) - 1'b1), "delete did not remove one entry")
	// A result appears only after an update step has completed.
	`SLSI_ASSERT(a_rsp_origin, $rose(rsp_valid_q) |-> $past(upd_go), "result without update step")

endmodule

/* test/tb_sorted_list_insert_delete_top.sv */
// Self-checking testbench for the sorted list insert and delete block.
`timescale 1ns / 100ps

module tb_sorted_list_insert_delete_top;

	localparam int LIST_DEPTH = slsi_pkg::CAPACITY_DEF;
	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	slsi_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	slsi_pkg::rsp_t rsp;

	// Our own view of the list: ascending values and how many are held.
	logic signed [31:0] list_vals [LIST_DEPTH];
	int list_len = 0;

	// Results still owed by the block, oldest first.
	slsi_pkg::rsp_t owed_results [$];
	slsi_pkg::rsp_t oldest_owed;

	int error_count = 0;
	int cycle_count = 0;
	int stall_left = 0;
	// When clear, neither side idles, so transfers run back to back.
	bit idle_on = 1'b1;

	sorted_list_insert_delete_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// The run is ended here if the block stops making progress.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_sorted_list_insert_delete_top failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("cycle %0d: %s: got %0d, expected %0d", cycle_count, what, got, want);
		error_count++;
	endtask

	// Applies one operation to our copy of the list and returns the result that
	// the block must give for it. Scanning from the top down leaves the lowest
	// matching rank in pos, so equal values go in after the existing ones and a
	// delete takes the first of them.
	function automatic slsi_pkg::rsp_t apply_list_op(input slsi_pkg::req_t item);
		slsi_pkg::rsp_t outcome;
		int pos;
		outcome = '0;
		outcome.status = slsi_pkg::ST_OK;
		case (item.opcode)
			slsi_pkg::OP_INSERT: begin
				if (list_len >= LIST_DEPTH) begin
					outcome.status = slsi_pkg::ST_FULL;
				end else begin
					pos = list_len;
					for (int i = list_len - 1; i >= 0; i--)
						if ($signed(list_vals[i]) > $signed(item.value))
							pos = i;
					for (int i = list_len; i > pos; i--)
						list_vals[i] = list_vals[i - 1];
					list_vals[pos] = item.value;
					list_len++;
				end
			end
			slsi_pkg::OP_DELETE: begin
				pos = list_len;
				for (int i = list_len - 1; i >= 0; i--)
					if (list_vals[i] == item.value)
						pos = i;
				if (pos >= list_len) begin
					outcome.status = slsi_pkg::ST_NOT_FOUND;
				end else begin
					for (int i = pos; i + 1 < list_len; i++)
						list_vals[i] = list_vals[i + 1];
					list_len--;
				end
			end
			slsi_pkg::OP_READ: begin
				if (int'(item.rank) >= list_len)
					outcome.status = slsi_pkg::ST_RANK;
				else
					outcome.read_value = list_vals[item.rank];
			end
			default: begin
				// The spare opcode does nothing and reports success.
			end
		endcase
		outcome.count = 5'(list_len);
		outcome.empty_res = (list_len == 0);
		return outcome;
	endfunction

	// Sends one request. It is called at a rising edge and returns at the edge
	// where the transfer took place, with valid still high, so that the next
	// request can follow without a gap.
	task automatic send_request(input slsi_pkg::opcode_t op,
			input logic signed [31:0] val, input logic [3:0] rnk);
		slsi_pkg::req_t item;
		int gap;
		item.opcode = op;
		item.value = val;
		item.rank = rnk;
		gap = idle_on ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		owed_results.push_back(apply_list_op(item));
	endtask

	// Result side: each transfer is checked against the oldest owed result, and
	// then a fresh stall of random length is drawn for the cycles that follow.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (owed_results.size() == 0) begin
				report_mismatch("result with nothing outstanding", 32'(rsp.status), 32'd0);
			end else begin
				oldest_owed = owed_results.pop_front();
				if (rsp.status !== oldest_owed.status)
					report_mismatch("status", 32'(rsp.status), 32'(oldest_owed.status));
				if (rsp.read_value !== oldest_owed.read_value)
					report_mismatch("read_value", rsp.read_value,
						oldest_owed.read_value);
				if (rsp.count !== oldest_owed.count)
					report_mismatch("count", 32'(rsp.count), 32'(oldest_owed.count));
				if (rsp.empty_res !== oldest_owed.empty_res)
					report_mismatch("empty_res", 32'(rsp.empty_res),
						32'(oldest_owed.empty_res));
			end
			stall_left = idle_on ? $urandom_range(0, 12) : 0;
		end
		if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left--;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Values are drawn so that duplicates, small magnitudes and both ends of
	// the signed range all turn up often.
	function automatic logic signed [31:0] pick_value();
		logic signed [31:0] val;
		case ($urandom_range(0, 3))
			0: val = $urandom;
			1: val = $signed($urandom_range(0, 9)) - 5;
			2: begin
				case ($urandom_range(0, 3))
					0: val = 32'sh7FFF_FFFF;
					1: val = 32'sh8000_0000;
					2: val = 32'sh0000_0000;
					default: val = 32'shFFFF_FFFF;
				endcase
			end
			default: val = $signed($urandom) >>> $urandom_range(0, 31);
		endcase
		return val;
	endfunction

	// Operations on an empty list, and the spare opcode with all field bits
	// low and all high.
	task automatic test_empty_list();
		send_request(slsi_pkg::OP_DELETE, 32'sd5, 4'd0);
		send_request(slsi_pkg::OP_READ, 32'sd0, 4'd0);
		send_request(slsi_pkg::OP_NOP, 32'shFFFF_FFFF, 4'hF);
		send_request(slsi_pkg::OP_NOP, 32'sh0000_0000, 4'h0);
	endtask

	// Both ends of the signed range, which must sort by sign and not as
	// unsigned numbers, then reads of every rank held and beyond it.
	task automatic test_value_extremes();
		send_request(slsi_pkg::OP_INSERT, 32'sh7FFF_FFFF, 4'd0);
		send_request(slsi_pkg::OP_INSERT, 32'sh8000_0000, 4'hF);
		send_request(slsi_pkg::OP_INSERT, 32'sd0, 4'd0);
		send_request(slsi_pkg::OP_INSERT, -32'sd1, 4'd0);
		send_request(slsi_pkg::OP_INSERT, 32'sd1, 4'd0);
		for (int r = 0; r <= 5; r++)
			send_request(slsi_pkg::OP_READ, 32'sd0, 4'(r));
		send_request(slsi_pkg::OP_READ, 32'shFFFF_FFFF, 4'hF);
	endtask

	// An equal value joins the existing one, a delete takes one of the pair, a
	// value absent from a non-empty list is not found and both ends are deleted.
	task automatic test_equal_values();
		send_request(slsi_pkg::OP_INSERT, 32'sd0, 4'd0);
		send_request(slsi_pkg::OP_READ, 32'sd0, 4'd2);
		send_request(slsi_pkg::OP_READ, 32'sd0, 4'd3);
		send_request(slsi_pkg::OP_DELETE, 32'sd0, 4'd0);
		send_request(slsi_pkg::OP_READ, 32'sd0, 4'd3);
		send_request(slsi_pkg::OP_DELETE, 32'sd7, 4'd0);
		send_request(slsi_pkg::OP_DELETE, 32'sh8000_0000, 4'd0);
		send_request(slsi_pkg::OP_DELETE, 32'sh7FFF_FFFF, 4'd0);
	endtask

	// Fills the list with random values, pushes against the full limit, reads
	// the top rank and then frees one place and fills it again.
	task automatic test_full_list();
		while (list_len < LIST_DEPTH)
			send_request(slsi_pkg::OP_INSERT, pick_value(), 4'($urandom));
		send_request(slsi_pkg::OP_INSERT, pick_value(), 4'd0);
		send_request(slsi_pkg::OP_INSERT, 32'sh8000_0000, 4'd0);
		send_request(slsi_pkg::OP_READ, 32'sd0, 4'hF);
		send_request(slsi_pkg::OP_READ, 32'sd0, 4'h0);
		send_request(slsi_pkg::OP_DELETE, list_vals[$urandom_range(0, LIST_DEPTH - 1)],
			4'd0);
		send_request(slsi_pkg::OP_INSERT, pick_value(), 4'd0);
	endtask

	// Random traffic in bursts that lean towards filling, draining or neither,
	// so that the list keeps passing between empty and full. Most deletes name
	// a value that is present; some bursts run with no idling on either side.
	task automatic test_random_traffic(input int num_items);
		int leaning;
		int pick;
		int ins_pct;
		int del_pct;
		for (int n = 0; n < num_items; n++) begin
			if (n % 40 == 0) begin
				leaning = $urandom_range(0, 2);
				idle_on = ($urandom_range(0, 3) != 0);
			end
			ins_pct = (leaning == 0) ? 60 : (leaning == 1) ? 20 : 35;
			del_pct = (leaning == 0) ? 20 : (leaning == 1) ? 60 : 35;
			pick = $urandom_range(0, 99);
			if (pick < ins_pct) begin
				send_request(slsi_pkg::OP_INSERT, pick_value(), 4'($urandom));
			end else if (pick < ins_pct + del_pct) begin
				if (list_len > 0 && $urandom_range(0, 3) != 0)
					send_request(slsi_pkg::OP_DELETE,
						list_vals[$urandom_range(0, list_len - 1)], 4'($urandom));
				else
					send_request(slsi_pkg::OP_DELETE, pick_value(), 4'($urandom));
			end else if (pick < 98) begin
				send_request(slsi_pkg::OP_READ, $urandom, 4'($urandom));
			end else begin
				send_request(slsi_pkg::OP_NOP, $urandom, 4'($urandom));
			end
		end
		idle_on = 1'b1;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_value_extremes();
		test_equal_values();
		test_full_list();
		test_random_traffic(800);

		// Drain: every owed result must arrive, and nothing may follow it.
		req_valid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (error_count == 0)
			$display("tb_sorted_list_insert_delete_top passed");
		else
			$display("tb_sorted_list_insert_delete_top failed");
		$finish;
	end

endmodule

/* sim.f */
+incdir+design
design/slsi_pkg.sv
design/slsi_cell.sv
design/sorted_list_insert_delete_top.sv
test/tb_sorted_list_insert_delete_top.sv
